>>> hw/rtl/kars_pkg.sv
// Shared types and constants for the key auto-repeat scanner.
package kars_pkg;

	// Field widths fixed by the item format.
	localparam int KEY_W   = 6;
	localparam int TIME_W  = 32;
	localparam int DELAY_W = 16;
	localparam int KIND_W  = 2;
	localparam int CFG_IDX_W = 2;

	// Input op codes as carried on the slave tuser.
	localparam logic [1:0] OP_PRESS   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;

	// Event kinds as carried on the master tuser.
	localparam logic [KIND_W-1:0] EVT_PRESS   = 2'd0;
	localparam logic [KIND_W-1:0] EVT_REPEAT  = 2'd1;
	localparam logic [KIND_W-1:0] EVT_RELEASE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST = 16'd300;
	localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = 16'd100;

	// Command classes handed from the front to the back.
	typedef enum logic [1:0] {
		CMD_PRESS,
		CMD_RELEASE,
		CMD_TICK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [KEY_W-1:0]   key;
		logic               in_range;
		logic [TIME_W-1:0]  time_ms;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic              last;
	} evt_t;

	typedef struct packed {
		logic               repeat_enable;
		logic [DELAY_W-1:0] initial_delay_ms;
		logic [DELAY_W-1:0] repeat_delay_ms;
	} cfg_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_PRIME,
		ENG_SCAN,
		ENG_FLUSH
	} eng_state_t;

endpackage

>>> hw/rtl/kars_front.sv
// Input side: accepts items and classifies them into commands.
module kars_front #(
	parameter int KEY_COUNT = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [1:0]                 s_tuser,  // op
	input  logic [39:0]                s_tdata,  // key_code, time_ms, zero pad
	input  logic                       q_full,
	output logic                       q_push,
	output kars_pkg::cmd_t             q_cmd
);
	import kars_pkg::*;

	logic            accept;
	logic [KEY_W:0]  key_ext;

	// Items are taken whenever the queue has room.
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// Decode the op; the unused code is accepted and dropped here.
	always_comb begin
		key_ext          = {1'b0, s_tdata[KEY_W-1:0]};
		q_cmd.key        = s_tdata[KEY_W-1:0];
		q_cmd.time_ms    = s_tdata[KEY_W+TIME_W-1:KEY_W];
		q_cmd.in_range   = key_ext < (KEY_W+1)'(KEY_COUNT);
		q_cmd.kind       = CMD_TICK;
		q_push           = 1'b0;
		unique case (s_tuser)
			OP_PRESS: begin
				q_cmd.kind = CMD_PRESS;
				q_push     = accept;
			end
			OP_RELEASE: begin
				q_cmd.kind = CMD_RELEASE;
				q_push     = accept;
			end
			OP_TICK: begin
				q_cmd.kind = CMD_TICK;
				q_push     = accept;
			end
			default: begin
				q_push     = 1'b0;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// A command is only queued when an item was actually taken.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> s_tvalid && !q_full)
		else $error("front pushed without an accepted item");
`endif

endmodule

>>> hw/rtl/kars_cmd_fifo.sv
// Two-entry command queue between the front and the back.
module kars_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kars_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            cmd_valid,
	output kars_pkg::cmd_t  cmd
);
	import kars_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = slot_q[rd_ptr_q];

	// Entry storage carries no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> cmd_valid)
		else $error("command queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("command queue pushed while full");
	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("command queue count out of range");
`endif

endmodule

>>> hw/rtl/kars_engine.sv
// Back side: per-key state, press/release handling, and the repeat scan.
module kars_engine #(
	parameter int KEY_COUNT = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  kars_pkg::cfg_t  cfg,
	input  logic            cmd_valid,
	input  kars_pkg::cmd_t  cmd,
	output logic            cmd_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output kars_pkg::evt_t  out_evt
);
	import kars_pkg::*;

	localparam int IW = $clog2(KEY_COUNT);

	eng_state_t              state_q, state_d;
	logic [KEY_COUNT-1:0]    held_q, resolved_q, repeating_q;
	logic [TIME_W-1:0]       time_mem [KEY_COUNT];
	logic [TIME_W-1:0]       rd_data_q;
	logic [IW-1:0]           rd_addr;
	logic                    mem_we;
	logic [IW-1:0]           mem_wa;
	logic [TIME_W-1:0]       mem_wd;
	logic [IW-1:0]           idx_q;
	logic [TIME_W-1:0]       now_q;
	logic                    pend_vld_q;
	logic [IW-1:0]           pend_key_q;
	logic                    out_vld_q;
	evt_t                    out_q;

	logic                    out_free;
	logic [IW-1:0]           cmd_slot;
	logic                    cmd_held;
	logic                    slot_held, slot_res, slot_rep;
	logic [TIME_W-1:0]       elapsed;
	logic [DELAY_W-1:0]      delay;
	logic                    fire;
	logic                    last_slot;
	logic                    advance;
	logic                    out_load;
	evt_t                    out_d;
	logic                    press_set, rel_clr, res_set, rep_set;
	logic                    pend_load, pend_clr;

	assign out_valid = out_vld_q;
	assign out_evt   = out_q;
	assign out_free  = !out_vld_q || out_ready;

	// Slot lookups for the command and the scan.
	assign cmd_slot  = cmd.key[IW-1:0];
	assign cmd_held  = held_q[cmd_slot];
	assign slot_held = held_q[idx_q];
	assign slot_res  = resolved_q[idx_q];
	assign slot_rep  = repeating_q[idx_q];
	assign delay     = slot_rep ? cfg.repeat_delay_ms : cfg.initial_delay_ms;
	assign elapsed   = now_q - rd_data_q;
	assign fire      = slot_held && slot_res &&
		(elapsed >= {{(TIME_W-DELAY_W){1'b0}}, delay});
	assign last_slot = idx_q == IW'(KEY_COUNT - 1);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (cmd_valid && cmd.kind == CMD_TICK && cfg.repeat_enable) begin
					state_d = ENG_PRIME;
				end
			end
			ENG_PRIME: begin
				state_d = ENG_SCAN;
			end
			ENG_SCAN: begin
				if (advance && last_slot) begin
					state_d = ENG_FLUSH;
				end
			end
			ENG_FLUSH: begin
				if (!pend_vld_q || out_free) begin
					state_d = ENG_IDLE;
				end
			end
			default: begin
				state_d = ENG_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		cmd_pop   = 1'b0;
		out_load  = 1'b0;
		out_d     = '{kind: EVT_REPEAT, key: KEY_W'(pend_key_q), last: 1'b1};
		press_set = 1'b0;
		rel_clr   = 1'b0;
		res_set   = 1'b0;
		rep_set   = 1'b0;
		pend_load = 1'b0;
		pend_clr  = 1'b0;
		advance   = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = idx_q;
		mem_wd    = now_q;
		rd_addr   = idx_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_PRESS: begin
							if (cmd.in_range && !cmd_held) begin
								if (out_free) begin
									cmd_pop   = 1'b1;
									out_load  = 1'b1;
									out_d     = '{kind: EVT_PRESS, key: cmd.key, last: 1'b1};
									press_set = 1'b1;
									mem_we    = 1'b1;
									mem_wa    = cmd_slot;
									mem_wd    = cmd.time_ms;
								end
							end else begin
								cmd_pop = 1'b1;
							end
						end
						CMD_RELEASE: begin
							if (out_free) begin
								cmd_pop  = 1'b1;
								out_load = 1'b1;
								out_d    = '{kind: EVT_RELEASE, key: cmd.key, last: 1'b1};
								rel_clr  = cmd.in_range;
							end
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			ENG_PRIME: begin
				rd_addr = '0;
			end
			ENG_SCAN: begin
				// A new repeat displaces the pending one into the output register.
				if (!(fire && pend_vld_q && !out_free)) begin
					advance = 1'b1;
					if (fire) begin
						mem_we    = 1'b1;
						rep_set   = 1'b1;
						pend_load = 1'b1;
						if (pend_vld_q) begin
							out_load = 1'b1;
							out_d    = '{kind: EVT_REPEAT, key: KEY_W'(pend_key_q), last: 1'b0};
						end
					end
					if (slot_held && !slot_res) begin
						res_set = 1'b1;
					end
				end
				rd_addr = advance ? (last_slot ? '0 : idx_q + 1'b1) : idx_q;
			end
			ENG_FLUSH: begin
				// The last repeat of a tick goes out marked last.
				if (pend_vld_q && out_free) begin
					out_load = 1'b1;
					pend_clr = 1'b1;
				end
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	// Time store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			time_mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= time_mem[rd_addr];
	end

	// Tick time and pending key payload.
	always_ff @(posedge clk) begin
		if (state_q == ENG_IDLE && cmd_valid && cmd.kind == CMD_TICK) begin
			now_q <= cmd.time_ms;
		end
		if (pend_load) begin
			pend_key_q <= idx_q;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// Control state and per-key flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ENG_IDLE;
			held_q      <= '0;
			resolved_q  <= '0;
			repeating_q <= '0;
			idx_q       <= '0;
			pend_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (press_set) begin
				held_q[cmd_slot]      <= 1'b1;
				resolved_q[cmd_slot]  <= 1'b0;
				repeating_q[cmd_slot] <= 1'b0;
			end
			if (rel_clr) begin
				held_q[cmd_slot] <= 1'b0;
			end
			if (res_set) begin
				resolved_q[idx_q] <= 1'b1;
			end
			if (rep_set) begin
				repeating_q[idx_q] <= 1'b1;
			end
			if (state_q == ENG_PRIME) begin
				idx_q <= '0;
			end else if (advance && !last_slot) begin
				idx_q <= idx_q + 1'b1;
			end
			if (pend_load) begin
				pend_vld_q <= 1'b1;
			end else if (pend_clr) begin
				pend_vld_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> (state_q == ENG_SCAN || state_q == ENG_FLUSH))
		else $error("pending repeat held outside a scan");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !out_d.last) |-> state_q == ENG_SCAN)
		else $error("non-final event loaded outside a scan");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ENG_PRIME |=> state_q == ENG_SCAN)
		else $error("scan did not start after priming the time read");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten while occupied");
`endif

endmodule

>>> hw/rtl/key_auto_repeat_scanner.sv
// Top level of the key auto-repeat scanner: configuration and the front/queue/back chain.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+-------------------------------------------
//   s_*      | in        | s_tvalid/s_tready | tuser op, tdata key_code and time_ms
//   m_*      | out       | m_tvalid/m_tready | tuser event_kind, tdata event_key, tlast
//   cfg_*    | in        | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// A press or release is handled in the back end straight from the head of the two-entry queue.
// A tick with repeat enabled is taken from the queue, primes the time-store read, makes one
// time-store read per key slot, and then sends the final repeat of the scan, if there is one.
// A full output register stalls the back end; the queue keeps taking items until it fills.
// Reset clears the key flags and the queue; the time store needs no clearing pass.
module key_auto_repeat_scanner #(
	parameter int KEY_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,     // op
	input  logic [39:0] s_tdata,     // key_code[5:0], time_ms[37:6], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,     // event_kind
	output logic [7:0]  m_tdata,     // event_key[5:0], zero pad
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import kars_pkg::*;

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_push;
	cmd_t  q_cmd;
	logic  cmd_valid;
	cmd_t  cmd;
	logic  cmd_pop;
	evt_t  evt;

	// Configuration registers; writes to unknown indexes are ignored.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_enable    <= 1'b1;
			cfg_q.initial_delay_ms <= INITIAL_DELAY_RST;
			cfg_q.repeat_delay_ms  <= REPEAT_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_REPEAT_ENABLE: cfg_q.repeat_enable    <= cfg_data[0];
				CFG_INITIAL_DELAY: cfg_q.initial_delay_ms <= cfg_data;
				CFG_REPEAT_DELAY:  cfg_q.repeat_delay_ms  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	kars_front #(
		.KEY_COUNT (KEY_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	kars_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (cmd_pop),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	kars_engine #(
		.KEY_COUNT (KEY_COUNT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_evt   (evt)
	);

	// Output packing.
	assign m_tuser = evt.kind;
	assign m_tdata = {2'b00, evt.key};
	assign m_tlast = evt.last;

endmodule
